// ===== rtl/vna_pkg.sv =====
package vna_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int ACC_WIDTH_DEF    = 48;
    localparam int IDX_W            = 10;
    localparam int POS_W            = 16;
    localparam int NRM_W            = 16;

    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_TRI  = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef struct packed {
        logic             zero;
        logic [NRM_W-1:0] nz;
        logic [NRM_W-1:0] ny;
        logic [NRM_W-1:0] nx;
    } norm_res_t;

endpackage

// ===== rtl/vna_norm.sv =====
module vna_norm #(
    parameter int ACC_WIDTH = vna_pkg::ACC_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [ACC_WIDTH-1:0] sx,
    input  logic signed [ACC_WIDTH-1:0] sy,
    input  logic signed [ACC_WIDTH-1:0] sz,
    output logic                        done,
    output vna_pkg::norm_res_t          res
);

    localparam logic [2:0] N_IDLE  = 3'd0;
    localparam logic [2:0] N_SHIFT = 3'd1;
    localparam logic [2:0] N_SQ    = 3'd2;
    localparam logic [2:0] N_ROOT  = 3'd3;
    localparam logic [2:0] N_DINIT = 3'd4;
    localparam logic [2:0] N_DIV   = 3'd5;

    logic [2:0]  st_reg;
    logic [63:0] m_reg [3];
    logic [2:0]  neg_reg;
    logic [61:0] prod_reg;
    logic [63:0] sq_reg;
    logic [1:0]  k_reg;
    logic [63:0] rt_n_reg;
    logic [63:0] rt_res_reg;
    logic [63:0] rt_bit_reg;
    logic [31:0] len_reg;
    logic [15:0] num_reg;
    logic [32:0] rem_reg;
    logic [3:0]  cnt_reg;
    logic [15:0] q_reg;
    logic        done_reg;
    vna_pkg::norm_res_t res_reg;

    logic [63:0] ext_x, ext_y, ext_z;
    logic [63:0] or_all;
    logic [63:0] m_sel;
    logic [63:0] rt_t;
    logic [45:0] nume;
    logic [32:0] rem2;
    logic        ge;
    logic [15:0] q_fin;
    logic [15:0] comp;

    function automatic logic [63:0] mag64(input logic [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    assign ext_x  = 64'(sx);
    assign ext_y  = 64'(sy);
    assign ext_z  = 64'(sz);
    assign or_all = m_reg[0] | m_reg[1] | m_reg[2];

    always_comb
    begin
        unique case (k_reg)
            2'd0:    m_sel = m_reg[0];
            2'd1:    m_sel = m_reg[1];
            2'd2:    m_sel = m_reg[2];
            default: m_sel = 64'd0;
        endcase
    end

    assign rt_t  = rt_res_reg + rt_bit_reg;
    assign nume  = 46'({m_sel[30:0], 14'd0}) + 46'(len_reg[31:1]);
    assign rem2  = {rem_reg[31:0], num_reg[15]};
    assign ge    = (rem2 >= {1'b0, len_reg});
    assign q_fin = {q_reg[14:0], ge};
    assign comp  = neg_reg[k_reg] ? (16'd0 - q_fin) : q_fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= N_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (st_reg)
                N_IDLE:
                begin
                    if (start)
                    begin
                        if (sx == '0 && sy == '0 && sz == '0)
                        begin
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            st_reg <= N_SHIFT;
                        end
                    end
                end
                N_SHIFT:
                begin
                    if (!(|or_all[63:31]) && or_all[30])
                    begin
                        st_reg <= N_SQ;
                    end
                end
                N_SQ:
                begin
                    if (k_reg == 2'd3)
                    begin
                        st_reg <= N_ROOT;
                    end
                end
                N_ROOT:
                begin
                    if (rt_bit_reg[0])
                    begin
                        st_reg <= N_DINIT;
                    end
                end
                N_DINIT:
                begin
                    st_reg <= N_DIV;
                end
                N_DIV:
                begin
                    if (cnt_reg == 4'd15)
                    begin
                        if (k_reg == 2'd2)
                        begin
                            st_reg   <= N_IDLE;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            st_reg <= N_DINIT;
                        end
                    end
                end
                default:
                begin
                    st_reg <= N_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    m_reg[0] <= mag64(ext_x);
                    m_reg[1] <= mag64(ext_y);
                    m_reg[2] <= mag64(ext_z);
                    neg_reg  <= {ext_z[63], ext_y[63], ext_x[63]};
                    k_reg    <= 2'd0;
                    sq_reg   <= 64'd0;
                    res_reg  <= '{zero: 1'b1, nz: '0, ny: '0, nx: '0};
                end
            end
            N_SHIFT:
            begin
                if (|or_all[63:31])
                begin
                    m_reg[0] <= m_reg[0] >> 1;
                    m_reg[1] <= m_reg[1] >> 1;
                    m_reg[2] <= m_reg[2] >> 1;
                end
                else if (!or_all[30])
                begin
                    m_reg[0] <= m_reg[0] << 1;
                    m_reg[1] <= m_reg[1] << 1;
                    m_reg[2] <= m_reg[2] << 1;
                end
            end
            N_SQ:
            begin
                prod_reg <= 62'(m_sel[30:0] * m_sel[30:0]);
                if (k_reg != 2'd0)
                begin
                    sq_reg <= sq_reg + 64'(prod_reg);
                end
                if (k_reg == 2'd3)
                begin
                    rt_n_reg   <= sq_reg + 64'(prod_reg);
                    rt_res_reg <= 64'd0;
                    rt_bit_reg <= 64'd1 << 62;
                    k_reg      <= 2'd0;
                    res_reg.zero <= 1'b0;
                end
                else
                begin
                    k_reg <= k_reg + 2'd1;
                end
            end
            N_ROOT:
            begin
                if (rt_n_reg >= rt_t)
                begin
                    rt_n_reg   <= rt_n_reg - rt_t;
                    rt_res_reg <= (rt_res_reg >> 1) + rt_bit_reg;
                    len_reg    <= 32'((rt_res_reg >> 1) + rt_bit_reg);
                end
                else
                begin
                    rt_res_reg <= rt_res_reg >> 1;
                    len_reg    <= 32'(rt_res_reg >> 1);
                end
                rt_bit_reg <= rt_bit_reg >> 2;
            end
            N_DINIT:
            begin
                rem_reg <= 33'(nume[45:16]);
                num_reg <= nume[15:0];
                cnt_reg <= 4'd0;
                q_reg   <= 16'd0;
            end
            N_DIV:
            begin
                rem_reg <= ge ? (rem2 - {1'b0, len_reg}) : rem2;
                num_reg <= num_reg << 1;
                q_reg   <= q_fin;
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    unique case (k_reg)
                        2'd0:    res_reg.nx <= comp;
                        2'd1:    res_reg.ny <= comp;
                        default: res_reg.nz <= comp;
                    endcase
                    k_reg <= k_reg + 2'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// ===== rtl/vertex_normal_accumulator.sv =====
// Area-weighted vertex normal accumulator. Words are taken one at a time: s_axis_tready is high
// only while the block is idle. A vertex load writes both memories; a triangle runs three position
// reads, a parallel multiply and three read-modify-writes of the sum memory, and a normal read
// runs the bit-serial shift normalizer, the 32-step square root and three 16-step dividers (a zero
// sum or an index out of range skips them). A finished normal waits in the output register while
// the next word is accepted; a read stalls only while that register still holds an earlier normal.
// Positions and sums live in two synchronous memories.
module vertex_normal_accumulator #(
    parameter int MAX_VERTICES = vna_pkg::MAX_VERTICES_DEF,
    parameter int ACC_WIDTH    = vna_pkg::ACC_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // vertex_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
    input  logic [87:0] s_axis_tdata,
    // action
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_index, normal_x, normal_y, normal_z, zero pad
    output logic [63:0] m_axis_tdata,
    // zero_length
    output logic [0:0]  m_axis_tuser
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int SW = 3 * ACC_WIDTH;
    localparam int IW = vna_pkg::IDX_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] T_RA   = 4'd1;
    localparam logic [3:0] T_RB   = 4'd2;
    localparam logic [3:0] T_RC   = 4'd3;
    localparam logic [3:0] T_DC   = 4'd4;
    localparam logic [3:0] T_MUL  = 4'd5;
    localparam logic [3:0] T_CRS  = 4'd6;
    localparam logic [3:0] T_SR   = 4'd7;
    localparam logic [3:0] T_SW   = 4'd8;
    localparam logic [3:0] R_S    = 4'd9;
    localparam logic [3:0] R_Q    = 4'd10;
    localparam logic [3:0] R_N    = 4'd11;
    localparam logic [3:0] R_OUT  = 4'd12;

    logic [47:0] pos_mem [MAX_VERTICES];
    logic [SW-1:0] sum_mem [MAX_VERTICES];

    logic [3:0]    state_reg;
    logic [47:0]   pos_q_reg;
    logic [SW-1:0] sum_q_reg;
    logic [AW-1:0] a_reg, b_reg, c_reg;
    logic [IW-1:0] vi_reg;
    logic          oor_reg;
    logic [1:0]    j_reg;
    logic [47:0]   pa_reg, pb_reg;
    logic signed [16:0] ab_reg [3];
    logic signed [16:0] ac_reg [3];
    logic signed [33:0] p_reg [6];
    logic signed [34:0] n_reg [3];
    logic          out_valid_reg;
    logic [63:0]   out_data_reg;
    logic          out_zero_reg;

    logic          accept;
    logic [IW-1:0] in_vi, in_a, in_b, in_c;
    logic          vi_ok, a_ok, b_ok, c_ok;
    logic          load_we;
    logic          sum_we;
    logic [AW-1:0] sum_waddr, sum_raddr, pos_raddr, cur_addr;
    logic [SW-1:0] sum_wdata;
    logic [ACC_WIDTH-1:0] new_x, new_y, new_z;
    logic          norm_done;
    vna_pkg::norm_res_t norm_res;
    vna_pkg::norm_res_t sel_res;

    function automatic logic signed [16:0] sub16(input logic [15:0] p, input logic [15:0] q);
        return $signed({p[15], p}) - $signed({q[15], q});
    endfunction

    function automatic logic [ACC_WIDTH-1:0] sat_add(input logic [ACC_WIDTH-1:0] s,
                                                     input logic signed [34:0] n);
        logic signed [ACC_WIDTH:0] t;
        t = $signed({s[ACC_WIDTH-1], s}) + (ACC_WIDTH+1)'(n);
        if (t[ACC_WIDTH] != t[ACC_WIDTH-1])
            return t[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}} : {1'b0, {(ACC_WIDTH-1){1'b1}}};
        return t[ACC_WIDTH-1:0];
    endfunction

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign in_vi = s_axis_tdata[9:0];
    assign in_a  = s_axis_tdata[67:58];
    assign in_b  = s_axis_tdata[77:68];
    assign in_c  = s_axis_tdata[87:78];
    assign vi_ok = (32'(in_vi) < MAX_VERTICES);
    assign a_ok  = (32'(in_a) < MAX_VERTICES);
    assign b_ok  = (32'(in_b) < MAX_VERTICES);
    assign c_ok  = (32'(in_c) < MAX_VERTICES);

    assign load_we = accept && (s_axis_tuser == vna_pkg::ACT_LOAD) && vi_ok;

    always_comb
    begin
        unique case (j_reg)
            2'd0:    cur_addr = a_reg;
            2'd1:    cur_addr = b_reg;
            default: cur_addr = c_reg;
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            T_RB:    pos_raddr = b_reg;
            T_RC:    pos_raddr = c_reg;
            default: pos_raddr = a_reg;
        endcase
    end

    assign sum_raddr = (state_reg == R_S) ? AW'(vi_reg) : cur_addr;

    assign new_x = sat_add(sum_q_reg[ACC_WIDTH-1:0], n_reg[0]);
    assign new_y = sat_add(sum_q_reg[2*ACC_WIDTH-1:ACC_WIDTH], n_reg[1]);
    assign new_z = sat_add(sum_q_reg[SW-1:2*ACC_WIDTH], n_reg[2]);

    assign sum_we    = load_we || (state_reg == T_SW);
    assign sum_waddr = load_we ? AW'(in_vi) : cur_addr;
    assign sum_wdata = load_we ? '0 : {new_z, new_y, new_x};

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            pos_mem[AW'(in_vi)] <= s_axis_tdata[57:10];
        end
        pos_q_reg <= pos_mem[pos_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sum_we)
        begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        sum_q_reg <= sum_mem[sum_raddr];
    end

    vna_norm #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == R_Q),
        .sx    (sum_q_reg[ACC_WIDTH-1:0]),
        .sy    (sum_q_reg[2*ACC_WIDTH-1:ACC_WIDTH]),
        .sz    (sum_q_reg[SW-1:2*ACC_WIDTH]),
        .done  (norm_done),
        .res   (norm_res)
    );

    assign sel_res = oor_reg ? '{zero: 1'b1, nz: '0, ny: '0, nx: '0} : norm_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (s_axis_tuser)
                            vna_pkg::ACT_TRI:
                            begin
                                if (a_ok && b_ok && c_ok)
                                begin
                                    state_reg <= T_RA;
                                end
                            end
                            vna_pkg::ACT_READ:
                            begin
                                state_reg <= vi_ok ? R_S : R_OUT;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                T_RA:  state_reg <= T_RB;
                T_RB:  state_reg <= T_RC;
                T_RC:  state_reg <= T_DC;
                T_DC:  state_reg <= T_MUL;
                T_MUL: state_reg <= T_CRS;
                T_CRS: state_reg <= T_SR;
                T_SR:  state_reg <= T_SW;
                T_SW:  state_reg <= (j_reg == 2'd2) ? S_IDLE : T_SR;
                R_S:   state_reg <= R_Q;
                R_Q:   state_reg <= R_N;
                R_N:
                begin
                    if (norm_done)
                    begin
                        state_reg <= R_OUT;
                    end
                end
                R_OUT:
                begin
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg   <= AW'(in_a);
            b_reg   <= AW'(in_b);
            c_reg   <= AW'(in_c);
            vi_reg  <= in_vi;
            oor_reg <= !vi_ok;
        end
        if (state_reg == T_RB)
        begin
            pa_reg <= pos_q_reg;
        end
        if (state_reg == T_RC)
        begin
            pb_reg <= pos_q_reg;
        end
        if (state_reg == T_DC)
        begin
            ab_reg[0] <= sub16(pa_reg[15:0],  pb_reg[15:0]);
            ab_reg[1] <= sub16(pa_reg[31:16], pb_reg[31:16]);
            ab_reg[2] <= sub16(pa_reg[47:32], pb_reg[47:32]);
            ac_reg[0] <= sub16(pa_reg[15:0],  pos_q_reg[15:0]);
            ac_reg[1] <= sub16(pa_reg[31:16], pos_q_reg[31:16]);
            ac_reg[2] <= sub16(pa_reg[47:32], pos_q_reg[47:32]);
        end
        if (state_reg == T_MUL)
        begin
            p_reg[0] <= ab_reg[1] * ac_reg[2];
            p_reg[1] <= ab_reg[2] * ac_reg[1];
            p_reg[2] <= ab_reg[2] * ac_reg[0];
            p_reg[3] <= ab_reg[0] * ac_reg[2];
            p_reg[4] <= ab_reg[0] * ac_reg[1];
            p_reg[5] <= ab_reg[1] * ac_reg[0];
        end
        if (state_reg == T_CRS)
        begin
            n_reg[0] <= 35'(p_reg[0]) - 35'(p_reg[1]);
            n_reg[1] <= 35'(p_reg[2]) - 35'(p_reg[3]);
            n_reg[2] <= 35'(p_reg[4]) - 35'(p_reg[5]);
            j_reg    <= 2'd0;
        end
        if (state_reg == T_SW)
        begin
            j_reg <= j_reg + 2'd1;
        end
        if (state_reg == R_OUT && (!out_valid_reg || m_axis_tready))
        begin
            out_data_reg <= {6'd0, sel_res.nz, sel_res.ny, sel_res.nx, vi_reg};
            out_zero_reg <= sel_res.zero;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_zero_reg;

endmodule
